### src/six_digit_seven_segment_scan_unit_assert.svh
// Assertion macros used by the seven-segment scan unit RTL.
`ifndef SIX_DIGIT_SEVEN_SEGMENT_SCAN_UNIT_ASSERT_SVH
`define SIX_DIGIT_SEVEN_SEGMENT_SCAN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define SSD_ASSERT(label, clk, rst, prop)
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/ssd_scan_pkg.sv
// Shared types, constants and conversion functions of the seven-segment scan unit.
`timescale 1ns / 1ps
package ssd_scan_pkg;

   localparam int DIGITS_DEFAULT = 6;
   localparam int MAX_DIGITS     = 8;
   localparam int VALUE_W        = 20;
   localparam int BCD_DIGITS     = 7;
   localparam int BCD_W          = 4 * BCD_DIGITS;
   localparam int STAGE_SHIFTS   = 4;
   localparam int STAGES         = VALUE_W / STAGE_SHIFTS;
   localparam int SEG_W          = 8;
   localparam int SEL_W          = 6;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 16;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic               op;
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
   } pipe_type;

   // Active-low segment pattern of one decimal digit.
   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
      logic [SEG_W-1:0] c;
      case (d)
         4'd0:    c = 8'hc0;
         4'd1:    c = 8'hf9;
         4'd2:    c = 8'ha4;
         4'd3:    c = 8'hb0;
         4'd4:    c = 8'h99;
         4'd5:    c = 8'h92;
         4'd6:    c = 8'h82;
         4'd7:    c = 8'hf8;
         4'd8:    c = 8'h80;
         4'd9:    c = 8'h90;
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   // A few steps of shift-and-add-3 binary to BCD conversion.
   function automatic pipe_type dabble(input pipe_type p);
      pipe_type q;
      q = p;
      for (int s = 0; s < STAGE_SHIFTS; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (q.bcd[d*4 +: 4] >= 4'd5) begin
               q.bcd[d*4 +: 4] = q.bcd[d*4 +: 4] + 4'd3;
            end
         end
         q.bcd = {q.bcd[BCD_W-2:0], q.bin[VALUE_W-1]};
         q.bin = {q.bin[VALUE_W-2:0], 1'b0};
      end
      return q;
   endfunction

endpackage

### src/ssd_scan_stage.sv
// One registered stage of the binary to BCD conversion pipeline.
`timescale 1ns / 1ps
module ssd_scan_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ssd_scan_pkg::pipe_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ssd_scan_pkg::pipe_type out_data
);

   logic                   valid_ff;
   logic                   valid_in;
   ssd_scan_pkg::pipe_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = ssd_scan_pkg::dabble(data_ff);

   always_comb begin
      if (in_ready) begin
         valid_in = in_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

### src/ssd_scan_out.sv
// Digit code store, scan position and response register.
`timescale 1ns / 1ps
`include "six_digit_seven_segment_scan_unit_assert.svh"
module ssd_scan_out #(
   parameter int DIGITS = ssd_scan_pkg::DIGITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  ssd_scan_pkg::pipe_type             in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [ssd_scan_pkg::SEG_W-1:0]     segments,
   output logic [ssd_scan_pkg::SEL_W-1:0]     digit_select
);

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [ssd_scan_pkg::SEG_W-1:0]          digit_codes_ff [DIGITS];
   logic [ssd_scan_pkg::SEG_W-1:0]          codes_in [DIGITS];
   logic [IDX_W-1:0]                        scan_index_ff;
   logic [IDX_W-1:0]                        scan_index_in;
   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   logic [ssd_scan_pkg::SEG_W-1:0]          seg_ff;
   logic [ssd_scan_pkg::SEL_W-1:0]          sel_ff;
   logic [ssd_scan_pkg::SEL_W-1:0]          sel_in;
   logic [4*ssd_scan_pkg::MAX_DIGITS-1:0]   bcd_ext;
   logic                                    take;
   logic                                    tick_take;
   logic                                    load_take;

   assign in_ready     = !out_valid_ff || out_ready;
   assign take         = in_valid && in_ready;
   assign tick_take    = take && (in_data.op == ssd_scan_pkg::OP_TICK);
   assign load_take    = take && (in_data.op == ssd_scan_pkg::OP_LOAD);
   assign out_valid    = out_valid_ff;
   assign segments     = seg_ff;
   assign digit_select = sel_ff;

   // Only the low DIGITS decimal digits are kept, which is the modulo reduction.
   // A digit shows when it or any more significant kept digit is nonzero; the units digit always shows.
   always_comb begin
      logic       seen;
      logic [3:0] d;
      int         place;
      bcd_ext = {{(4*ssd_scan_pkg::MAX_DIGITS-ssd_scan_pkg::BCD_W){1'b0}}, in_data.bcd};
      seen    = 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
         place = DIGITS - 1 - k;
         d     = bcd_ext[place*4 +: 4];
         seen  = seen || (d != 4'd0);
         if (seen || (place == 0)) begin
            codes_in[k] = ssd_scan_pkg::seg_code(d);
         end else begin
            codes_in[k] = ssd_scan_pkg::SEG_BLANK;
         end
      end
   end

   always_comb begin
      for (int b = 0; b < ssd_scan_pkg::SEL_W; b++) begin
         if (b < DIGITS) begin
            sel_in[b] = (32'(scan_index_ff) != 32'(DIGITS - 1 - b));
         end else begin
            sel_in[b] = 1'b0;
         end
      end
   end

   always_comb begin
      scan_index_in = scan_index_ff;
      if (tick_take) begin
         if (scan_index_ff == IDX_W'(DIGITS - 1)) begin
            scan_index_in = '0;
         end else begin
            scan_index_in = scan_index_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      if (tick_take) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= '0;
         out_valid_ff  <= 1'b0;
         for (int k = 0; k < DIGITS; k++) begin
            digit_codes_ff[k] <= ssd_scan_pkg::SEG_BLANK;
         end
      end else begin
         scan_index_ff <= scan_index_in;
         out_valid_ff  <= out_valid_in;
         if (load_take) begin
            for (int k = 0; k < DIGITS; k++) begin
               digit_codes_ff[k] <= codes_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_take) begin
         seg_ff <= digit_codes_ff[scan_index_ff];
         sel_ff <= sel_in;
      end
   end

   `SSD_ASSERT(a_index_range, clock, reset, 32'(scan_index_ff) < DIGITS)
   `SSD_ASSERT(a_one_digit_on, clock, reset,
      !out_valid_ff || (DIGITS > ssd_scan_pkg::SEL_W) || ($countones(sel_ff) == DIGITS - 1))
   `SSD_ASSERT_NEXT(a_load_silent, clock, reset, load_take && !out_valid_ff, !out_valid_ff)
   `SSD_ASSERT_NEXT(a_stall_holds_scan, clock, reset, out_valid_ff && !out_ready,
      $stable(scan_index_ff))

endmodule

### src/six_digit_seven_segment_scan_unit.sv
// Top level of the six-digit multiplexed seven-segment scan unit.
`timescale 1ns / 1ps
// A load request (tuser 1) takes a binary number, keeps its low DIGITS
// decimal digits, blanks leading zeros (the units digit always shows) and
// stores the active-low segment codes; it gives no response. A scan tick
// request (tuser 0) gives one response with the stored code of the current
// digit and an active-low one-cold digit select, leftmost digit first, then
// steps the scan position. One request is accepted every clock cycle unless
// the response side stalls. A response passes through five conversion
// stages of four shift-and-add-3 steps each, then the response register.
// Requests are handled strictly in order, so a tick sees every earlier load.
// The digit store resets to blank.
module six_digit_seven_segment_scan_unit #(
   parameter int DIGITS = ssd_scan_pkg::DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // value in [19:0], zeros above
   input  logic [ssd_scan_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op: 0 scan tick, 1 load
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // segments in [7:0], digit_select in [13:8], zeros above
   output logic [ssd_scan_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int STAGES = ssd_scan_pkg::STAGES;

   ssd_scan_pkg::pipe_type             pipe_data  [STAGES+1];
   logic                               pipe_valid [STAGES+1];
   logic                               pipe_ready [STAGES+1];
   logic [ssd_scan_pkg::SEG_W-1:0]     segments;
   logic [ssd_scan_pkg::SEL_W-1:0]     digit_select;

   assign pipe_valid[0]    = req_tvalid;
   assign req_tready       = pipe_ready[0];
   assign pipe_data[0].op  = req_tuser;
   assign pipe_data[0].bin = req_tdata[ssd_scan_pkg::VALUE_W-1:0];
   assign pipe_data[0].bcd = '0;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      ssd_scan_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[k]),
         .in_ready  (pipe_ready[k]),
         .in_data   (pipe_data[k]),
         .out_valid (pipe_valid[k+1]),
         .out_ready (pipe_ready[k+1]),
         .out_data  (pipe_data[k+1])
      );
   end

   ssd_scan_out #(
      .DIGITS (DIGITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pipe_valid[STAGES]),
      .in_ready     (pipe_ready[STAGES]),
      .in_data      (pipe_data[STAGES]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .segments     (segments),
      .digit_select (digit_select)
   );

   assign rsp_tdata = {
      {(ssd_scan_pkg::RSP_TDATA_W - ssd_scan_pkg::SEG_W - ssd_scan_pkg::SEL_W){1'b0}},
      digit_select,
      segments
   };

endmodule

### dv/tb_six_digit_seven_segment_scan_unit.sv
// Self-checking testbench of the six-digit seven-segment scan unit.
`timescale 1ns / 1ps
module tb_six_digit_seven_segment_scan_unit;

   localparam int          DIGITS          = ssd_scan_pkg::DIGITS_DEFAULT;
   localparam int          VALUE_W         = ssd_scan_pkg::VALUE_W;
   localparam int          SEG_W           = ssd_scan_pkg::SEG_W;
   localparam int          SEL_W           = ssd_scan_pkg::SEL_W;
   localparam int          REQ_TDATA_W     = ssd_scan_pkg::REQ_TDATA_W;
   localparam int          RSP_TDATA_W     = ssd_scan_pkg::RSP_TDATA_W;
   localparam int          LATENCY_SLACK   = 20;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned DISPLAY_MOD     = 1000000;

   // Active-low glyphs of the digits 0 to 9, digit 0 in the lowest byte.
   localparam logic [79:0] GLYPHS = {
      8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
   };

   typedef struct packed {
      logic [SEL_W-1:0] digit_select;
      logic [SEG_W-1:0] segments;
   } scan_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // value in [19:0], zeros above
   logic [REQ_TDATA_W-1:0] req_tdata;
   // op: 0 scan tick, 1 load
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // segments in [7:0], digit_select in [13:8], zeros above
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [SEG_W-1:0] shown_codes [DIGITS];
   logic [2:0]       scan_pos;
   scan_result_type  pending_scans [$];
   int unsigned      mismatch_count;
   int unsigned      cycle_count;
   bit               tx_idle_on;
   bit               rx_idle_on;
   bit               hold_off_req;

   six_digit_seven_segment_scan_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Mirrors the display state for each accepted request.
   task automatic predict_display(input logic op, input logic [VALUE_W-1:0] value);
      int unsigned     v;
      int unsigned     weight;
      int unsigned     d;
      scan_result_type r;
      if (op == ssd_scan_pkg::OP_LOAD) begin
         v = value % DISPLAY_MOD;
         weight = DISPLAY_MOD;
         for (int k = 0; k < DIGITS; k++) begin
            weight = weight / 10;
            d = (v / weight) % 10;
            // Leading zeros stay blank, but the units digit always shows.
            if (weight == 1 || v >= weight) begin
               shown_codes[k] = GLYPHS[d*8 +: 8];
            end else begin
               shown_codes[k] = ssd_scan_pkg::SEG_BLANK;
            end
         end
      end else begin
         r.segments = shown_codes[scan_pos];
         r.digit_select = ~(SEL_W'(1) << (DIGITS - 1 - scan_pos));
         pending_scans.push_back(r);
         scan_pos = (scan_pos == DIGITS - 1) ? 3'd0 : scan_pos + 3'd1;
      end
   endtask

   task automatic send_request(input logic op, input logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {{(REQ_TDATA_W - VALUE_W){1'b0}}, value};
      do @(posedge clock); while (!req_tready);
      predict_display(op, value);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned p;
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = VALUE_W'($urandom_range(0, 20'hfffff));
         1: v = VALUE_W'($urandom_range(0, 99));
         2: begin
            // Just below, at and just above a power of ten.
            p = 1;
            repeat ($urandom_range(0, 6)) p = p * 10;
            v = VALUE_W'(p - 1 + $urandom_range(0, 2));
         end
         default: v = VALUE_W'($urandom_range(990000, 20'hfffff));
      endcase
      return v;
   endfunction

   task automatic test_blank_after_reset();
      repeat (DIGITS) send_request(ssd_scan_pkg::OP_TICK, '0);
   endtask

   task automatic test_directed_loads();
      // 1000000 wraps to zero: only the units digit shows.
      send_request(ssd_scan_pkg::OP_LOAD, 20'd1000000);
      repeat (6) send_request(ssd_scan_pkg::OP_TICK, '0);
      // The largest field value keeps only its low six digits.
      send_request(ssd_scan_pkg::OP_LOAD, 20'hfffff);
      repeat (3) send_request(ssd_scan_pkg::OP_TICK, '0);
      // A load leaves the scan position where it was.
      send_request(ssd_scan_pkg::OP_LOAD, 20'd123456);
      repeat (3) send_request(ssd_scan_pkg::OP_TICK, '0);
      send_request(ssd_scan_pkg::OP_LOAD, 20'd0);
      send_request(ssd_scan_pkg::OP_TICK, '0);
      send_request(ssd_scan_pkg::OP_LOAD, 20'd999999);
      send_request(ssd_scan_pkg::OP_TICK, '0);
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned ticks;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(ssd_scan_pkg::OP_TICK, VALUE_W'($urandom_range(0, 20'hfffff)));
            sent++;
         end else begin
            send_request(ssd_scan_pkg::OP_LOAD, pick_value());
            ticks = $urandom_range(0, 12);
            repeat (ticks) begin
               send_request(ssd_scan_pkg::OP_TICK, VALUE_W'($urandom_range(0, 20'hfffff)));
            end
            sent += ticks + 1;
         end
      end
   endtask

   task automatic test_full_rate(input int unsigned count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random_traffic(count);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_output_hold_off();
      tx_idle_on = 1'b0;
      hold_off_req = 1'b1;
      send_request(ssd_scan_pkg::OP_LOAD, pick_value());
      repeat (60) send_request(ssd_scan_pkg::OP_TICK, '0);
      tx_idle_on = 1'b1;
   endtask

   // Response side: random pauses per response, and a long hold-off on demand.
   initial begin : response_sink
      int unsigned pause;
      rsp_tready = 1'b0;
      pause = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (pause > 0) begin
            rsp_tready = 1'b0;
            pause--;
         end else begin
            rsp_tready = 1'b1;
         end
         @(posedge clock);
         if (rsp_tready && rsp_tvalid) begin
            pause = rx_idle_on ? $urandom_range(0, 6) : 0;
         end
      end
   end

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scans.size() == 0) begin
            $error("unexpected response, tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_scans.pop_front();
            if (rsp_tdata[7:0] !== want.segments) begin
               $error("segments: expected %h, got %h", want.segments, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tdata[13:8] !== want.digit_select) begin
               $error("digit_select: expected %b, got %b", want.digit_select,
                      rsp_tdata[13:8]);
               mismatch_count++;
            end
            if (rsp_tdata[15:14] !== 2'b00) begin
               $error("tdata padding: expected 00, got %b", rsp_tdata[15:14]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout with %0d responses outstanding", pending_scans.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = ssd_scan_pkg::OP_TICK;
      req_tdata    = '0;
      tx_idle_on   = 1'b1;
      rx_idle_on   = 1'b1;
      hold_off_req = 1'b0;
      mismatch_count = 0;
      cycle_count  = 0;
      scan_pos     = '0;
      for (int k = 0; k < DIGITS; k++) shown_codes[k] = ssd_scan_pkg::SEG_BLANK;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_blank_after_reset();
      test_directed_loads();
      test_random_traffic(1200);
      test_full_rate(300);
      test_output_hold_off();
      test_random_traffic(400);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/ssd_scan_pkg.sv
src/ssd_scan_stage.sv
src/ssd_scan_out.sv
src/six_digit_seven_segment_scan_unit.sv
dv/tb_six_digit_seven_segment_scan_unit.sv
